### hw/rtl/oal_pkg.sv
// Shared constants, codes and types for the ordered array list.
`timescale 1ns / 1ps

package oal_pkg;

   // Storage shape
   localparam int CAPACITY     = 32;
   localparam int KEY_BITS     = 64;
   localparam int PAYLOAD_BITS = 32;

   // Port field widths (fixed by the interface)
   localparam int OP_W   = 3;
   localparam int POS_W  = 6;
   localparam int KEY_W  = 64;
   localparam int PAY_W  = 32;
   localparam int FPOS_W = 5;
   localparam int CNTP_W = 6;

   // Derived internal widths
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   // Broadcast to every cell for one beat
   typedef struct packed {
      logic             ins_do;
      logic             del_do;
      logic             upd_do;
      logic             get_do;
      logic             find_do;
      logic [CMP_W-1:0] pos;
      logic [CMP_W-1:0] ins_pos;
      logic [CMP_W-1:0] count;
      entry_type        item;
   } cell_ctrl_type;

   // Per-cell contribution to the result, already gated
   typedef struct packed {
      logic [IDX_W-1:0] fpos;
      entry_type        rd;
   } cell_rsp_type;

endpackage

### hw/rtl/oal_cell.sv
// One storage cell of the list: holds an entry, shifts with its neighbors.
`timescale 1ns / 1ps

module oal_cell
   import oal_pkg::*;
(
   input  logic          clock,
   input  logic [CMP_W-1:0] cell_index,
   input  logic          cmd_valid,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   input  logic          seen_in,
   output logic          seen_out,
   output entry_type     entry,
   output cell_rsp_type  rsp
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      load_new;
   logic      load_left;
   logic      load_right;
   logic      live;
   logic      hit;
   logic      sel;

   always_comb begin
      load_new   = 1'b0;
      load_left  = 1'b0;
      load_right = 1'b0;
      if (cmd_valid && ctrl.ins_do) begin
         if (cell_index == ctrl.ins_pos) begin
            load_new = 1'b1;
         end else if (cell_index > ctrl.ins_pos && cell_index <= ctrl.count) begin
            load_left = 1'b1;
         end
      end
      if (cmd_valid && ctrl.del_do && cell_index >= ctrl.pos &&
          ({1'b0, cell_index} + (CMP_W+1)'(1)) < {1'b0, ctrl.count}) begin
         load_right = 1'b1;
      end
      if (cmd_valid && ctrl.upd_do && cell_index == ctrl.pos) begin
         load_new = 1'b1;
      end
   end

   always_comb begin
      priority if (load_new) begin
         entry_in = ctrl.item;
      end else if (load_left) begin
         entry_in = left_entry;
      end else if (load_right) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Match chain: first hit from the low end wins
   assign live     = cell_index < ctrl.count;
   assign hit      = ctrl.find_do && live && (entry_ff.key == ctrl.item.key);
   assign seen_out = seen_in | hit;
   assign sel      = ctrl.get_do && (cell_index == ctrl.pos);

   assign entry    = entry_ff;
   assign rsp.fpos = (hit && !seen_in) ? cell_index[IDX_W-1:0] : '0;
   assign rsp.rd   = sel ? entry_ff : '0;

endmodule

### hw/rtl/ordered_array_list.sv
// Top level of the ordered array list: command decode, cell row, result register.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY (key, payload) entries held in a row of cells.
// Request channel (req_*): one beat carries operation, position, key and payload.
//   Ops: insert (before position, append at/past count), delete, get, update,
//   find (lowest position with equal key). A beat is taken when req_valid is
//   high and req_stall is low.
// Response channel (rsp_*): exactly one beat per request, in order, with success,
//   found position, read key/payload and the entry count after the operation.
// Timing: the response is registered; it is in the output register in the cycle
//   after the request beat. Throughput: one request per cycle while req_stall is
//   low; every cell shifts, writes and compares in parallel as the beat is taken,
//   and the match and read results are reduced along the row into the register.
// Stall: while rsp_stall holds a waiting response, req_stall is raised and the
//   response stays put; the request side resumes the cycle the beat is taken.
// Reset: synchronous, active high; clears the count and the response valid.
//   Entry storage is not cleared; only positions below the count are ever read.

module ordered_array_list
   import oal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [POS_W-1:0]  req_position,
   input  logic [KEY_W-1:0]  req_item_key,
   input  logic [PAY_W-1:0]  req_item_payload,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_success,
   output logic [FPOS_W-1:0] rsp_found_position,
   output logic [KEY_W-1:0]  rsp_read_key,
   output logic [PAY_W-1:0]  rsp_read_payload,
   output logic [CNTP_W-1:0] rsp_entry_count
);

   // Element count
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Response register
   logic              rsp_valid_ff,   rsp_valid_in;
   logic              rsp_success_ff, rsp_success_in;
   logic [IDX_W-1:0]  rsp_fpos_ff,    rsp_fpos_in;
   entry_type         rsp_rd_ff,      rsp_rd_in;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic              accept;
   logic              is_ins, is_del, is_get, is_upd, is_find;
   logic [CMP_W-1:0]  pos_w;
   logic [CMP_W-1:0]  cnt_w;
   logic              pos_ok;
   logic              room;
   cell_ctrl_type     ctrl;

   entry_type         cell_entry [CAPACITY];
   cell_rsp_type      cell_rsp   [CAPACITY];
   logic [CAPACITY:0] seen;

   cell_rsp_type      rsp_or;

   // Hold the request side only while a finished response is stuck
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ---- Decode ----
   assign is_ins  = (req_operation == OP_INSERT);
   assign is_del  = (req_operation == OP_DELETE);
   assign is_get  = (req_operation == OP_GET);
   assign is_upd  = (req_operation == OP_UPDATE);
   assign is_find = (req_operation == OP_FIND);

   assign pos_w  = CMP_W'(req_position);
   assign cnt_w  = CMP_W'(count_ff);
   assign pos_ok = pos_w < cnt_w;
   assign room   = count_ff < CNT_W'(CAPACITY);

   always_comb begin
      ctrl.ins_do       = is_ins && room;
      ctrl.del_do       = is_del && pos_ok;
      ctrl.upd_do       = is_upd && pos_ok;
      ctrl.get_do       = is_get && pos_ok;
      ctrl.find_do      = is_find;
      ctrl.pos          = pos_w;
      ctrl.ins_pos      = (pos_w > cnt_w) ? cnt_w : pos_w; // clamp to append
      ctrl.count        = cnt_w;
      ctrl.item.key     = req_item_key[KEY_BITS-1:0];
      ctrl.item.payload = req_item_payload[PAYLOAD_BITS-1:0];
   end

   // ---- Cell row ----
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;

      if (i == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_mid_l
         assign left_e = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_mid_r
         assign right_e = cell_entry[i+1];
      end

      oal_cell u_cell (
         .clock       (clock),
         .cell_index  (CMP_W'(i)),
         .cmd_valid   (accept),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .right_entry (right_e),
         .seen_in     (seen[i]),
         .seen_out    (seen[i+1]),
         .entry       (cell_entry[i]),
         .rsp         (cell_rsp[i])
      );
   end

   // At most one cell contributes per field, so an OR collects it
   always_comb begin
      rsp_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rsp_or = rsp_or | cell_rsp[i];
      end
   end

   // ---- Next state ----
   always_comb begin
      count_in = count_ff;
      if (accept && ctrl.ins_do) begin
         count_in = count_ff + CNT_W'(1);
      end else if (accept && ctrl.del_do) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_success_in = ctrl.ins_do || ctrl.del_do || ctrl.upd_do || ctrl.get_do ||
                       (is_find && seen[CAPACITY]);
      rsp_fpos_in    = rsp_or.fpos;
      rsp_rd_in      = rsp_or.rd;
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---- Registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_success_ff <= rsp_success_in;
         rsp_fpos_ff    <= rsp_fpos_in;
         rsp_rd_ff      <= rsp_rd_in;
         rsp_count_ff   <= count_in;
      end
   end

   // ---- Outputs ----
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_success_ff;
   assign rsp_found_position = FPOS_W'(rsp_fpos_ff);
   assign rsp_read_key       = KEY_W'(rsp_rd_ff.key);
   assign rsp_read_payload   = PAY_W'(rsp_rd_ff.payload);
   assign rsp_entry_count    = CNTP_W'(rsp_count_ff);

endmodule

### hw/rtl/oal_checker.sv
// Port-level checks for the ordered array list, bound to the top level.
`timescale 1ns / 1ps

module oal_checker
   import oal_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_success,
   input logic [FPOS_W-1:0] rsp_found_position,
   input logic [KEY_W-1:0]  rsp_read_key,
   input logic [PAY_W-1:0]  rsp_read_payload,
   input logic [CNTP_W-1:0] rsp_entry_count
);

   // Count never runs past capacity
   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNTP_W'(CAPACITY)))
      else $error("entry count above capacity");

   // A failed operation reports zero position and zero read data
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |->
         (rsp_found_position == '0 && rsp_read_key == '0 && rsp_read_payload == '0))
      else $error("failed beat carries nonzero data");

   // Read data only comes from an existing entry
   a_read_nonempty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_read_key != '0 || rsp_read_payload != '0)) |->
         (rsp_success && rsp_entry_count != '0))
      else $error("read data with empty list");

   // Stalled response beat holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_entry_count) && $stable(rsp_success)))
      else $error("stalled response changed");

   // An accepted request beat shows up as a response on the next cycle
   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("request beat without response");

endmodule

bind ordered_array_list oal_checker u_oal_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_success        (rsp_success),
   .rsp_found_position (rsp_found_position),
   .rsp_read_key       (rsp_read_key),
   .rsp_read_payload   (rsp_read_payload),
   .rsp_entry_count    (rsp_entry_count)
);

### dv/tb_ordered_array_list.sv
// Testbench for the ordered array list: directed table, random runs, shadow-list check.
`timescale 1ns / 1ps

// What is exercised:
//   - a directed table: empty-list errors, the unused operation codes, append
//     past the count, insert at the head and in the middle, duplicate keys for
//     find, delete at head and tail, get/update one past the end and at the top
//     position value;
//   - random runs shaped as fill / mixed / drain blocks, so the list goes all the
//     way to full (and refuses inserts) and back down to empty, again and again;
//   - four idling phases (none, sender idle, receiver stalling, both), one long
//     receiver hold-off while the sender keeps offering, and sender pauses that
//     wait for every owed response.
// How it is checked:
//   - a monitor takes every accepted request beat, runs it through a shadow
//     copy of the list and queues the expected response;
//   - every accepted response beat is compared field by field with the oldest
//     queued one; an extra response or one still owed at the end is an error;
//   - a watchdog ends the run when no beat moves for too long.

module tb_ordered_array_list;
   import oal_pkg::*;

   // Operation codes the block does not use; they must leave the list alone.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   localparam int HALF_PERIOD  = 4;     // 8 ns clock
   localparam int RESET_CYCLES = 4;
   localparam int IDLE_LIMIT   = 1000;  // cycles with no beat on either side
   localparam int HOLD_OFF     = 80;    // long receiver hold-off, in cycles
   localparam int SETTLE       = 4;     // response sits one register behind the request

   typedef struct packed {
      logic              success;
      logic [FPOS_W-1:0] found_position;
      logic [KEY_W-1:0]  read_key;
      logic [PAY_W-1:0]  read_payload;
      logic [CNTP_W-1:0] entry_count;
   } list_rsp_type;

   // One request beat; when known is set, rsp is the response typed in by hand.
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      logic             known;
      list_rsp_type     rsp;
   } list_cmd_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [OP_W-1:0]   req_operation;
   logic [POS_W-1:0]  req_position;
   logic [KEY_W-1:0]  req_item_key;
   logic [PAY_W-1:0]  req_item_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_success;
   logic [FPOS_W-1:0] rsp_found_position;
   logic [KEY_W-1:0]  rsp_read_key;
   logic [PAY_W-1:0]  rsp_read_payload;
   logic [CNTP_W-1:0] rsp_entry_count;

   // Hand-typed response travels with the request beat it belongs to.
   logic              beat_known;
   list_rsp_type      beat_known_rsp;

   // Shadow copy of the list, advanced once per accepted request beat.
   logic [KEY_BITS-1:0]     shadow_keys [CAPACITY];
   logic [PAYLOAD_BITS-1:0] shadow_pays [CAPACITY];
   int                      shadow_count;

   list_rsp_type owed_rsp [$];
   list_cmd_type directed_cmds [$];

   int idle_pct;
   int stall_pct;
   int hold_request;
   int hold_left;
   int errors;
   int idle_cycles;
   int beats_taken;
   int refused_ops;
   int find_hits;
   int full_refusals;
   int full_reached;

   ordered_array_list dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_item_key       (req_item_key),
      .req_item_payload   (req_item_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_found_position (rsp_found_position),
      .rsp_read_key       (rsp_read_key),
      .rsp_read_payload   (rsp_read_payload),
      .rsp_entry_count    (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Applies one operation to the shadow list and returns the response it owes.
   function automatic list_rsp_type apply_list_op(logic [OP_W-1:0] op,
                                                  logic [POS_W-1:0] pos,
                                                  logic [KEY_W-1:0] key,
                                                  logic [PAY_W-1:0] payload);
      list_rsp_type r;
      int p;
      int i;
      r = '0;
      p = int'(pos);
      unique case (op)
         OP_INSERT: begin
            if (shadow_count < CAPACITY) begin
               // at or past the count means append
               if (p > shadow_count) p = shadow_count;
               for (i = shadow_count; i > p; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_pays[i] = shadow_pays[i-1];
               end
               shadow_keys[p] = key[KEY_BITS-1:0];
               shadow_pays[p] = payload[PAYLOAD_BITS-1:0];
               shadow_count++;
               r.success = 1'b1;
            end
         end
         OP_DELETE: begin
            if (p < shadow_count) begin
               for (i = p; i + 1 < shadow_count; i++) begin
                  shadow_keys[i] = shadow_keys[i+1];
                  shadow_pays[i] = shadow_pays[i+1];
               end
               shadow_count--;
               r.success = 1'b1;
            end
         end
         OP_GET: begin
            if (p < shadow_count) begin
               r.read_key     = KEY_W'(shadow_keys[p]);
               r.read_payload = PAY_W'(shadow_pays[p]);
               r.success      = 1'b1;
            end
         end
         OP_UPDATE: begin
            if (p < shadow_count) begin
               shadow_keys[p] = key[KEY_BITS-1:0];
               shadow_pays[p] = payload[PAYLOAD_BITS-1:0];
               r.success = 1'b1;
            end
         end
         OP_FIND: begin
            // lowest matching position wins
            for (i = 0; i < shadow_count; i++) begin
               if (!r.success && shadow_keys[i] == key[KEY_BITS-1:0]) begin
                  r.found_position = FPOS_W'(i);
                  r.success        = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      r.entry_count = CNTP_W'(shadow_count);
      return r;
   endfunction

   // Monitor: request beats feed the shadow list, response beats are checked.
   always @(posedge clock) begin : beat_monitor
      list_rsp_type want;
      list_rsp_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = apply_list_op(req_operation, req_position, req_item_key, req_item_payload);
            beats_taken++;
            if (!want.success) refused_ops++;
            if (req_operation == OP_FIND && want.success) find_hits++;
            if (req_operation == OP_INSERT && !want.success) full_refusals++;
            if (req_operation == OP_INSERT && want.success && shadow_count == CAPACITY)
               full_reached++;
            if (beat_known) want = beat_known_rsp;
            owed_rsp.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp.size() == 0) begin
               report_mismatch("response beat with nothing owed");
            end else begin
               want = owed_rsp.pop_front();
               got  = '{rsp_success, rsp_found_position, rsp_read_key,
                        rsp_read_payload, rsp_entry_count};
               if (got.success !== want.success)
                  report_mismatch($sformatf("success %b, want %b", got.success, want.success));
               if (got.found_position !== want.found_position)
                  report_mismatch($sformatf("found_position %0d, want %0d",
                                            got.found_position, want.found_position));
               if (got.read_key !== want.read_key)
                  report_mismatch($sformatf("read_key %h, want %h",
                                            got.read_key, want.read_key));
               if (got.read_payload !== want.read_payload)
                  report_mismatch($sformatf("read_payload %h, want %h",
                                            got.read_payload, want.read_payload));
               if (got.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count %0d, want %0d",
                                            got.entry_count, want.entry_count));
            end
         end
      end
   end

   // Watchdog: any beat on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d responses owed",
                     idle_cycles, owed_rsp.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // Receiver: random stall at stall_pct, or a counted hold-off when requested.
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Offers one beat, starting and ending on a falling edge; the payload holds
   // until the beat is taken.
   task automatic send_cmd(list_cmd_type c);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= c.op;
      req_position     <= c.pos;
      req_item_key     <= c.key;
      req_item_payload <= c.payload;
      beat_known       <= c.known;
      beat_known_rsp   <= c.rsp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Sender goes quiet until every owed response has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (owed_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic row(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                      logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
      directed_cmds.push_back('{op, pos, key, payload, 1'b0, list_rsp_type'('0)});
   endtask

   // Row whose response is plain: nothing read back, only success and count.
   task automatic row_known(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                            logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload,
                            logic ok, int count);
      list_rsp_type r;
      r = '0;
      r.success     = ok;
      r.entry_count = CNTP_W'(count);
      directed_cmds.push_back('{op, pos, key, payload, 1'b1, r});
   endtask

   // Random beat built around the current shadow list, so finds hit, positions
   // mostly land inside the list and the fill level follows the insert bias.
   function automatic list_cmd_type gen_cmd(int ins_pct, int del_pct);
      list_cmd_type c;
      int r;
      c = '0;
      r = $urandom_range(99);
      if (r < ins_pct) begin
         c.op = OP_INSERT;
      end else if (r < ins_pct + del_pct) begin
         c.op = OP_DELETE;
      end else begin
         r = $urandom_range(99);
         if (r < 30) c.op = OP_GET;
         else if (r < 55) c.op = OP_UPDATE;
         else if (r < 93) c.op = OP_FIND;
         else c.op = OP_W'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
      end
      if ($urandom_range(99) < 85) c.pos = POS_W'($urandom_range(0, shadow_count));
      else c.pos = POS_W'($urandom);
      r = $urandom_range(99);
      if (r < 40 && shadow_count > 0)
         c.key = KEY_W'(shadow_keys[$urandom_range(0, shadow_count-1)]);
      else if (r < 60) c.key = KEY_W'($urandom_range(0, 7));   // small pool: duplicates
      else c.key = {$urandom, $urandom};
      c.payload = $urandom;
      return c;
   endfunction

   task automatic send_block(int ins_pct, int del_pct, int n);
      repeat (n) send_cmd(gen_cmd(ins_pct, del_pct));
   endtask

   // One idling phase: fill to full, churn, drain to empty, churn again.
   task automatic run_phase(int s_idle, int r_stall);
      idle_pct  = s_idle;
      stall_pct = r_stall;
      send_block(75, 5, 65);
      send_block(30, 30, 70);
      send_block(5, 70, 65);
      send_block(35, 25, 65);
      pause_until_drained();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_INSERT;
      req_position     = '0;
      req_item_key     = '0;
      req_item_payload = '0;
      beat_known       = 1'b0;
      beat_known_rsp   = '0;
      shadow_count     = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      hold_request     = 0;
      errors           = 0;
      idle_cycles      = 0;
      beats_taken      = 0;
      refused_ops      = 0;
      find_hits        = 0;
      full_refusals    = 0;
      full_reached     = 0;

      // Directed table. Empty list first: every position is out of range.
      row_known(OP_GET,      6'd0,  '0, '0, 1'b0, 0);
      row_known(OP_DELETE,   6'd0,  '0, '0, 1'b0, 0);
      row_known(OP_UPDATE,   6'd63, '1, '1, 1'b0, 0);
      row_known(OP_FIND,     6'd0,  '0, '0, 1'b0, 0);
      row_known(OP_SPARE_LO, 6'd0,  '0, '0, 1'b0, 0);
      row_known(OP_SPARE_HI, 6'd63, '1, '1, 1'b0, 0);
      // Append from far past the count, then head and middle inserts.
      row_known(OP_INSERT,   6'd63, '1, '1, 1'b1, 1);
      row_known(OP_INSERT,   6'd0,  '0, '0, 1'b1, 2);
      row_known(OP_INSERT,   6'd1,  64'h5A5A_5A5A_A5A5_A5A5, 32'hA5A5_5A5A, 1'b1, 3);
      row(OP_GET,    6'd0, '0, '0);
      row(OP_GET,    6'd2, '0, '0);
      // Duplicate key: find must report the lowest position.
      row_known(OP_INSERT,   6'd3,  '0, 32'h1, 1'b1, 4);
      row(OP_FIND,   6'd0, '0, '0);
      row(OP_FIND,   6'd0, '1, '0);
      row_known(OP_DELETE,   6'd0,  '0, '0, 1'b1, 3);
      row(OP_FIND,   6'd0, '0, '0);
      row(OP_UPDATE, 6'd1, 64'h1, 32'h2);
      row(OP_GET,    6'd1, '0, '0);
      // One past the end, tail delete, top position value.
      row_known(OP_GET,      6'd3,  '0, '0, 1'b0, 3);
      row_known(OP_DELETE,   6'd2,  '0, '0, 1'b1, 2);
      row_known(OP_UPDATE,   6'd2,  '1, '1, 1'b0, 2);
      row_known(OP_GET,      6'd63, '0, '0, 1'b0, 2);
      row_known(OP_FIND,     6'd0,  64'h123, '0, 1'b0, 2);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);
      pause_until_drained();

      // Back-to-back, no stalls.
      run_phase(0, 0);

      // Long receiver hold-off while the sender keeps pushing: the block fills
      // its output and must stall the request side.
      hold_request = HOLD_OFF;
      send_block(40, 10, 40);
      pause_until_drained();

      run_phase(58, 0);
      run_phase(0, 58);
      run_phase(37, 37);

      pause_until_drained();
      repeat (SETTLE) @(negedge clock);
      if (owed_rsp.size() != 0)
         report_mismatch($sformatf("%0d responses still owed at end", owed_rsp.size()));

      $display("run covered %0d requests: %0d refused, %0d find hits, list full %0d times",
               beats_taken, refused_ops, find_hits, full_reached);
      $display("inserts refused on a full list: %0d, mismatches: %0d",
               full_refusals, errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
